// ===== hw/rtl/svg_pkg.sv =====
package svg_pkg;

    localparam int CNT_W       = 13;
    localparam int RAD_W       = 16;
    localparam int REM_W       = CNT_W + 1;
    localparam int DIV_STEPS   = 32;
    localparam int QUO_W       = DIV_STEPS + 1;
    localparam int TEX_TAP     = 16;
    localparam int TEX_W       = TEX_TAP + 1;
    localparam int ROT_W       = 34;
    localparam int Q15_W       = 16;
    localparam int POS_W       = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 136;
    localparam int ATAN_ENTRIES = 24;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int MAX_DIVISIONS_DEF = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECTORS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STACKS  = 2'd2;

    localparam logic [RAD_W-1:0] RADIUS_RST  = 16'd256;
    localparam logic [CNT_W-1:0] SECTORS_RST = 13'd36;
    localparam logic [CNT_W-1:0] STACKS_RST  = 13'd18;

    localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } svg_div_t;

    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] z;
        logic [1:0]              quad;
    } svg_rot_t;

    function automatic logic signed [Q15_W-1:0] sat_q15(input logic signed [ROT_W-1:0] v);
        logic signed [ROT_W-1:0] r;
        r = (v + 34'sd16384) >>> 15;
        if (r > 34'sd32767)
            return 16'sd32767;
        else if (r < -34'sd32767)
            return -16'sd32767;
        else
            return r[Q15_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/svg_delay.sv =====
module svg_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int k = 1; k < DEPTH; k++)
            begin
                tap_reg[k] <= tap_reg[k-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

// ===== hw/rtl/svg_div_cell.sv =====
module svg_div_cell (
    input  logic                          clk,
    input  logic                          en,
    input  logic [svg_pkg::CNT_W-1:0]     divisor,
    input  svg_pkg::svg_div_t             d_in,
    output svg_pkg::svg_div_t             d_out
);

    svg_pkg::svg_div_t        d_reg;
    svg_pkg::svg_div_t        d_next;
    logic [svg_pkg::REM_W-1:0] rem2;
    logic                     ge;

    always_comb
    begin
        rem2 = {d_in.rem[svg_pkg::REM_W-2:0], 1'b0};
        ge   = rem2 >= {1'b0, divisor};
        d_next.rem = ge ? rem2 - {1'b0, divisor} : rem2;
        d_next.quo = {d_in.quo[svg_pkg::QUO_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// ===== hw/rtl/svg_div.sv =====
module svg_div (
    input  logic                      clk,
    input  logic                      en,
    input  logic [svg_pkg::CNT_W-1:0] divisor,
    input  logic [svg_pkg::CNT_W-1:0] dividend,
    output logic [svg_pkg::QUO_W-1:0] quo,
    output logic [svg_pkg::REM_W-1:0] rem,
    output logic [svg_pkg::TEX_W-1:0] tex
);

    svg_pkg::svg_div_t         stage [svg_pkg::DIV_STEPS+1];
    logic                      whole;
    logic [svg_pkg::CNT_W-1:0] half;
    logic [svg_pkg::REM_W:0]   tap_sum;
    logic [svg_pkg::TEX_W-1:0] tex_next;
    logic [svg_pkg::TEX_W-1:0] tex_reg;

    assign whole = dividend == divisor;
    assign half  = divisor >> 1;
    assign stage[0].rem = whole ? '0 : {1'b0, dividend};
    assign stage[0].quo = {{(svg_pkg::QUO_W-1){1'b0}}, whole};

    for (genvar k = 0; k < svg_pkg::DIV_STEPS; k++)
    begin : g_cell
        svg_div_cell u_cell (
            .clk     (clk),
            .en      (en),
            .divisor (divisor),
            .d_in    (stage[k]),
            .d_out   (stage[k+1])
        );
    end

    assign tap_sum  = {1'b0, stage[svg_pkg::TEX_TAP].rem} + {2'b00, half};
    assign tex_next = stage[svg_pkg::TEX_TAP].quo[svg_pkg::TEX_W-1:0]
                    + {{(svg_pkg::TEX_W-1){1'b0}}, (tap_sum >= {2'b00, divisor})};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tex_reg <= tex_next;
        end
    end

    svg_delay #(
        .WIDTH (svg_pkg::TEX_W),
        .DEPTH (svg_pkg::DIV_STEPS - svg_pkg::TEX_TAP - 1)
    ) u_tex_dly (
        .clk  (clk),
        .en   (en),
        .din  (tex_reg),
        .dout (tex)
    );

    assign quo = stage[svg_pkg::DIV_STEPS].quo;
    assign rem = stage[svg_pkg::DIV_STEPS].rem;

endmodule

// ===== hw/rtl/svg_cordic_cell.sv =====
module svg_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              en,
    input  svg_pkg::svg_rot_t r_in,
    output svg_pkg::svg_rot_t r_out
);

    localparam logic signed [svg_pkg::ROT_W-1:0] ANGLE =
        svg_pkg::ROT_W'(svg_pkg::ATAN_TURNS[STEP]);

    svg_pkg::svg_rot_t                r_reg;
    svg_pkg::svg_rot_t                r_next;
    logic signed [svg_pkg::ROT_W-1:0] dx;
    logic signed [svg_pkg::ROT_W-1:0] dy;

    always_comb
    begin
        dx = r_in.y >>> STEP;
        dy = r_in.x >>> STEP;
        r_next.quad = r_in.quad;
        if (!r_in.z[svg_pkg::ROT_W-1])
        begin
            r_next.x = r_in.x - dx;
            r_next.y = r_in.y + dy;
            r_next.z = r_in.z - ANGLE;
        end
        else
        begin
            r_next.x = r_in.x + dx;
            r_next.y = r_in.y - dy;
            r_next.z = r_in.z + ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg <= r_next;
        end
    end

    assign r_out = r_reg;

endmodule

// ===== hw/rtl/svg_cordic.sv =====
module svg_cordic #(
    parameter int STAGES = svg_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic [31:0]                       phase,
    output logic signed [svg_pkg::Q15_W-1:0]  cos_q15,
    output logic signed [svg_pkg::Q15_W-1:0]  sin_q15
);

    svg_pkg::svg_rot_t                rot [STAGES+1];
    svg_pkg::svg_rot_t                pre_next;
    logic [31:0]                      biased;
    logic [31:0]                      resid;
    logic signed [svg_pkg::ROT_W-1:0] c_full;
    logic signed [svg_pkg::ROT_W-1:0] s_full;
    logic signed [svg_pkg::Q15_W-1:0] cos_reg;
    logic signed [svg_pkg::Q15_W-1:0] sin_reg;

    always_comb
    begin
        biased = phase + 32'h2000_0000;
        resid  = phase - {biased[31:30], 30'd0};
        pre_next.quad = biased[31:30];
        pre_next.x    = svg_pkg::CORDIC_GAIN;
        pre_next.y    = '0;
        pre_next.z    = {{(svg_pkg::ROT_W-32){resid[31]}}, resid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot[0] <= pre_next;
        end
    end

    for (genvar k = 0; k < STAGES; k++)
    begin : g_cell
        svg_cordic_cell #(
            .STEP (k)
        ) u_cell (
            .clk   (clk),
            .en    (en),
            .r_in  (rot[k]),
            .r_out (rot[k+1])
        );
    end

    always_comb
    begin
        case (rot[STAGES].quad)
            2'd0:
            begin
                c_full = rot[STAGES].x;
                s_full = rot[STAGES].y;
            end
            2'd1:
            begin
                c_full = -rot[STAGES].y;
                s_full = rot[STAGES].x;
            end
            2'd2:
            begin
                c_full = -rot[STAGES].x;
                s_full = -rot[STAGES].y;
            end
            default:
            begin
                c_full = rot[STAGES].y;
                s_full = -rot[STAGES].x;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= svg_pkg::sat_q15(c_full);
            sin_reg <= svg_pkg::sat_q15(s_full);
        end
    end

    assign cos_q15 = cos_reg;
    assign sin_q15 = sin_reg;

endmodule

// ===== hw/rtl/uv_sphere_vertex_generator.sv =====
// UV sphere vertex generator.
// Input stream s_*: one beat per grid point, tdata = {sector_index, stack_index}.
// Output stream m_*: one beat per input beat, in order, carrying position (Q8.8),
// unit normal (Q1.15) and texture coordinates (Q1.16).
// Configuration: cfg_we with cfg_index 0 radius, 1 sector count, 2 stack count;
// other indexes are ignored. Write only while no beat is in flight.
// Throughput: one beat per cycle while the output is not stalled. The pipeline is
// made of the 32 long-division cells per angle and the CORDIC rotation cells, plus
// input, rounding, two quadrant and three multiply stages.
// The whole pipeline advances together: when m_tvalid is high and m_tready is
// low, every stage holds and s_tready drops; s_tready stays high while the output
// register is empty or being drained, so a new beat enters as a result leaves.
// Reset clears all valid flags and loads radius 1.0, 36 sectors and 18 stacks.
module uv_sphere_vertex_generator #(
    parameter int CORDIC_STAGES = svg_pkg::CORDIC_STAGES_DEF,
    parameter int MAX_DIVISIONS = svg_pkg::MAX_DIVISIONS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [svg_pkg::IN_DATA_W-1:0]   s_tdata,   // stack_index, sector_index
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [svg_pkg::OUT_DATA_W-1:0]  m_tdata,   // pos_x, pos_y, pos_z, norm_x,
                                                       // norm_y, norm_z, tex_s, tex_t
    input  logic                            cfg_we,
    input  logic [svg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [svg_pkg::RAD_W-1:0]       cfg_data
);

    localparam int LAT = CORDIC_STAGES + 39;
    localparam int CW  = svg_pkg::CNT_W;
    localparam logic [CW-1:0] COUNT_CAP =
        (MAX_DIVISIONS > 8191) ? 13'd8191 : CW'(MAX_DIVISIONS);
    localparam logic [CW-1:0] SEC_USED_RST =
        (svg_pkg::SECTORS_RST > COUNT_CAP) ? COUNT_CAP : svg_pkg::SECTORS_RST;
    localparam logic [CW-1:0] STK_USED_RST =
        (svg_pkg::STACKS_RST > COUNT_CAP) ? COUNT_CAP : svg_pkg::STACKS_RST;

    logic                 en;
    logic [LAT-1:0]       vld_reg;

    logic [svg_pkg::RAD_W-1:0] radius_reg;
    logic [CW-1:0]             sec_used_reg;
    logic [CW-1:0]             stk_used_reg;
    logic [CW-1:0]             sec_used_next;
    logic [CW-1:0]             stk_used_next;

    logic [CW-1:0] stk_in;
    logic [CW-1:0] sec_in;
    logic [CW-1:0] stk_idx_reg;
    logic [CW-1:0] sec_idx_reg;

    logic [svg_pkg::QUO_W-1:0] sec_quo;
    logic [svg_pkg::REM_W-1:0] sec_rem;
    logic [svg_pkg::TEX_W-1:0] sec_tex;
    logic [svg_pkg::QUO_W-1:0] stk_quo;
    logic [svg_pkg::REM_W-1:0] stk_rem;
    logic [svg_pkg::TEX_W-1:0] stk_tex;

    logic [svg_pkg::REM_W:0]   sec_sum;
    logic [svg_pkg::REM_W:0]   stk_r31;
    logic [svg_pkg::REM_W:0]   stk_sum;
    logic [31:0]               stk_q31;
    logic [31:0]               sec_phase_reg;
    logic [31:0]               stk_phase_reg;
    logic [31:0]               sec_phase_next;
    logic [31:0]               stk_phase_next;

    logic signed [15:0] cu;
    logic signed [15:0] su;
    logic signed [15:0] cv;
    logic signed [15:0] sv;
    logic signed [16:0] rad_s;

    logic signed [31:0] nxp_reg;
    logic signed [31:0] nyp_reg;
    logic signed [32:0] pzp_reg;
    logic signed [32:0] rcu_reg;
    logic signed [15:0] cv_reg;
    logic signed [15:0] sv_reg;
    logic signed [15:0] nz1_reg;

    logic signed [48:0] pxp_reg;
    logic signed [48:0] pyp_reg;
    logic signed [15:0] nx2_reg;
    logic signed [15:0] ny2_reg;
    logic signed [15:0] nz2_reg;
    logic signed [16:0] pz2_reg;
    logic signed [31:0] nx_rnd;
    logic signed [31:0] ny_rnd;
    logic signed [32:0] pz_rnd;
    logic signed [48:0] px_rnd;
    logic signed [48:0] py_rnd;

    logic signed [16:0] pos_x_reg;
    logic signed [16:0] pos_y_reg;
    logic signed [16:0] pos_z_reg;
    logic signed [15:0] norm_x_reg;
    logic signed [15:0] norm_y_reg;
    logic signed [15:0] norm_z_reg;
    logic [svg_pkg::TEX_W-1:0] tex_s_dly;
    logic [svg_pkg::TEX_W-1:0] tex_t_dly;

    function automatic logic [CW-1:0] used_count(input logic [CW-1:0] n);
        if (n == '0)
        begin
            return 13'd1;
        end
        else if (n > COUNT_CAP)
        begin
            return COUNT_CAP;
        end
        return n;
    endfunction

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    always_comb
    begin
        sec_used_next = sec_used_reg;
        stk_used_next = stk_used_reg;
        if (cfg_we && cfg_index == svg_pkg::REG_SECTORS)
        begin
            sec_used_next = used_count(cfg_data[CW-1:0]);
        end
        if (cfg_we && cfg_index == svg_pkg::REG_STACKS)
        begin
            stk_used_next = used_count(cfg_data[CW-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg   <= svg_pkg::RADIUS_RST;
            sec_used_reg <= SEC_USED_RST;
            stk_used_reg <= STK_USED_RST;
            vld_reg      <= '0;
        end
        else
        begin
            sec_used_reg <= sec_used_next;
            stk_used_reg <= stk_used_next;
            if (cfg_we && cfg_index == svg_pkg::REG_RADIUS)
            begin
                radius_reg <= cfg_data;
            end
            if (en)
            begin
                vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
            end
        end
    end

    // clamp indexes to the active counts
    assign stk_in = (s_tdata[12:0] > stk_used_reg) ? stk_used_reg : s_tdata[12:0];
    assign sec_in = (s_tdata[25:13] > sec_used_reg) ? sec_used_reg : s_tdata[25:13];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stk_idx_reg <= stk_in;
            sec_idx_reg <= sec_in;
        end
    end

    svg_div u_sec_div (
        .clk      (clk),
        .en       (en),
        .divisor  (sec_used_reg),
        .dividend (sec_idx_reg),
        .quo      (sec_quo),
        .rem      (sec_rem),
        .tex      (sec_tex)
    );

    svg_div u_stk_div (
        .clk      (clk),
        .en       (en),
        .divisor  (stk_used_reg),
        .dividend (stk_idx_reg),
        .quo      (stk_quo),
        .rem      (stk_rem),
        .tex      (stk_tex)
    );

    // round both quotients; the stack angle uses one fraction bit less
    always_comb
    begin
        sec_sum        = {1'b0, sec_rem} + {2'b00, sec_used_reg >> 1};
        sec_phase_next = sec_quo[31:0]
                       + {31'd0, (sec_sum >= {2'b00, sec_used_reg})};
        stk_q31        = stk_quo[32:1];
        stk_r31        = ({1'b0, stk_rem}
                       + (stk_quo[0] ? {2'b00, stk_used_reg} : '0)) >> 1;
        stk_sum        = stk_r31 + {2'b00, stk_used_reg >> 1};
        stk_phase_next = 32'h4000_0000
                       - (stk_q31 + {31'd0, (stk_sum >= {2'b00, stk_used_reg})});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sec_phase_reg <= sec_phase_next;
            stk_phase_reg <= stk_phase_next;
        end
    end

    svg_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_stk_cordic (
        .clk     (clk),
        .en      (en),
        .phase   (stk_phase_reg),
        .cos_q15 (cu),
        .sin_q15 (su)
    );

    svg_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_sec_cordic (
        .clk     (clk),
        .en      (en),
        .phase   (sec_phase_reg),
        .cos_q15 (cv),
        .sin_q15 (sv)
    );

    svg_delay #(
        .WIDTH (svg_pkg::TEX_W),
        .DEPTH (CORDIC_STAGES + 6)
    ) u_tex_s_dly (
        .clk  (clk),
        .en   (en),
        .din  (sec_tex),
        .dout (tex_s_dly)
    );

    svg_delay #(
        .WIDTH (svg_pkg::TEX_W),
        .DEPTH (CORDIC_STAGES + 6)
    ) u_tex_t_dly (
        .clk  (clk),
        .en   (en),
        .din  (stk_tex),
        .dout (tex_t_dly)
    );

    assign rad_s = $signed({1'b0, radius_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nxp_reg <= cu * cv;
            nyp_reg <= cu * sv;
            pzp_reg <= rad_s * su;
            rcu_reg <= rad_s * cu;
            cv_reg  <= cv;
            sv_reg  <= sv;
            nz1_reg <= su;
        end
    end

    assign nx_rnd = (nxp_reg + 32'sd16384) >>> 15;
    assign ny_rnd = (nyp_reg + 32'sd16384) >>> 15;
    assign pz_rnd = (pzp_reg + 33'sd16384) >>> 15;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxp_reg <= rcu_reg * cv_reg;
            pyp_reg <= rcu_reg * sv_reg;
            nx2_reg <= nx_rnd[15:0];
            ny2_reg <= ny_rnd[15:0];
            nz2_reg <= nz1_reg;
            pz2_reg <= pz_rnd[16:0];
        end
    end

    assign px_rnd = (pxp_reg + 49'sd536870912) >>> 30;
    assign py_rnd = (pyp_reg + 49'sd536870912) >>> 30;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_x_reg  <= px_rnd[16:0];
            pos_y_reg  <= py_rnd[16:0];
            pos_z_reg  <= pz2_reg;
            norm_x_reg <= nx2_reg;
            norm_y_reg <= ny2_reg;
            norm_z_reg <= nz2_reg;
        end
    end

    assign m_tdata = {3'd0, tex_t_dly, tex_s_dly, norm_z_reg, norm_y_reg, norm_x_reg,
                      pos_z_reg, pos_y_reg, pos_x_reg};

endmodule

// ===== hw/rtl/svg_checker.sv =====
module svg_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("output beat changed while stalled");

    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    a_tex_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[115:99] <= 17'h10000) && (m_tdata[132:116] <= 17'h10000))
        else $error("texture coordinate above one");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind uv_sphere_vertex_generator svg_checker u_svg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
